>>> hw/rtl/klc_pkg.sv
// klc_pkg: shared types, constants and the scancode keymap of the line editor console
// used by every module of keyboard_line_editor_text_console; depends on nothing
`default_nettype none

package klc_pkg;

  // screen geometry and line limit
  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int LINE_MAX    = 128;
  localparam int CELL_TOTAL  = COLUMNS * ROWS;
  localparam int TOP_CELLS   = (ROWS - 1) * COLUMNS;

  localparam int CELL_AW     = 11;
  localparam int COL_W       = $clog2(COLUMNS);
  localparam int ROW_W       = $clog2(ROWS);
  localparam int LINE_W      = 7;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [15:0] BLANK_CELL = 16'h0720;
  localparam logic [7:0]  ATTR_RESET = 8'h07;
  localparam logic [7:0]  SC_ENTER   = 8'h1C;
  localparam logic [7:0]  SC_BACK    = 8'h0E;

  typedef enum logic [2:0] {
    KIND_READ,
    KIND_NOP,
    KIND_ENTER,
    KIND_BACK,
    KIND_CHAR
  } klc_kind_e;

  typedef struct packed {
    klc_kind_e           kind;
    logic [7:0]          ch;
    logic [7:0]          attr;
    logic [CELL_AW-1:0]  addr;
  } klc_cmd_t;

  // set-1 make code to character, zero where no character is produced
  function automatic logic [7:0] keymap(input logic [6:0] sc);
    logic [7:0] ch;
    case (sc)
      7'd1:  ch = 8'h1B;
      7'd2:  ch = 8'h31;
      7'd3:  ch = 8'h32;
      7'd4:  ch = 8'h33;
      7'd5:  ch = 8'h34;
      7'd6:  ch = 8'h35;
      7'd7:  ch = 8'h36;
      7'd8:  ch = 8'h37;
      7'd9:  ch = 8'h38;
      7'd10: ch = 8'h39;
      7'd11: ch = 8'h30;
      7'd12: ch = 8'h2D;
      7'd13: ch = 8'h3D;
      7'd14: ch = 8'h08;
      7'd15: ch = 8'h09;
      7'd16: ch = 8'h71;
      7'd17: ch = 8'h77;
      7'd18: ch = 8'h65;
      7'd19: ch = 8'h72;
      7'd20: ch = 8'h74;
      7'd21: ch = 8'h79;
      7'd22: ch = 8'h75;
      7'd23: ch = 8'h69;
      7'd24: ch = 8'h6F;
      7'd25: ch = 8'h70;
      7'd26: ch = 8'h5B;
      7'd27: ch = 8'h5D;
      7'd28: ch = 8'h0A;
      7'd30: ch = 8'h61;
      7'd31: ch = 8'h73;
      7'd32: ch = 8'h64;
      7'd33: ch = 8'h66;
      7'd34: ch = 8'h67;
      7'd35: ch = 8'h68;
      7'd36: ch = 8'h6A;
      7'd37: ch = 8'h6B;
      7'd38: ch = 8'h6C;
      7'd39: ch = 8'h3B;
      7'd40: ch = 8'h27;
      7'd41: ch = 8'h60;
      7'd43: ch = 8'h5C;
      7'd44: ch = 8'h7A;
      7'd45: ch = 8'h78;
      7'd46: ch = 8'h63;
      7'd47: ch = 8'h76;
      7'd48: ch = 8'h62;
      7'd49: ch = 8'h6E;
      7'd50: ch = 8'h6D;
      7'd51: ch = 8'h2C;
      7'd52: ch = 8'h2E;
      7'd53: ch = 8'h2F;
      7'd55: ch = 8'h2A;
      7'd57: ch = 8'h20;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/klc_front.sv
// klc_front: accepts items, holds the attribute register and classifies each item
// into a command for the queue; depends on klc_pkg
`default_nettype none

module klc_front import klc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic               op_i,
  input  wire logic [7:0]         scancode_i,
  input  wire logic [CELL_AW-1:0] cell_address_i,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [7:0]         cfg_data_i,
  input  wire logic               q_full_i,
  input  wire logic               clearing_i,
  output logic                    push_o,
  output klc_cmd_t                cmd_o
);

  logic [7:0] attr_q, attr_d;
  logic [7:0] ch;

  assign cfg_ready_o = 1'b1;
  assign attr_d      = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : attr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else begin
      attr_q <= attr_d;
    end
  end

  assign busy_o = q_full_i || clearing_i;
  assign push_o = start_i && !busy_o;
  assign ch     = keymap(scancode_i[6:0]);

  // classify: read, release, enter, backspace, mapped key or unmapped key
  always_comb begin
    cmd_o.ch   = ch;
    cmd_o.attr = attr_q;
    cmd_o.addr = cell_address_i;
    if (op_i) begin
      cmd_o.kind = KIND_READ;
    end else if (scancode_i[7]) begin
      cmd_o.kind = KIND_NOP;
    end else if (scancode_i == SC_ENTER) begin
      cmd_o.kind = KIND_ENTER;
    end else if (scancode_i == SC_BACK) begin
      cmd_o.kind = KIND_BACK;
    end else if (ch != 8'h00) begin
      cmd_o.kind = KIND_CHAR;
    end else begin
      cmd_o.kind = KIND_NOP;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/klc_queue.sv
// klc_queue: short command queue between the front and the back
// depends on klc_pkg for the command type and depth
`default_nettype none

module klc_queue import klc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  klc_cmd_t      cmd_i,
  input  wire logic     pop_i,
  output klc_cmd_t      cmd_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  klc_cmd_t            entry_q [QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;

  assign full_o  = (count_q == CntW'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign cmd_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/klc_back.sv
// klc_back: carries out queued commands on the screen memory, cursor and line count,
// runs the clearing pass and the scroll copy; depends on klc_pkg
`default_nettype none

module klc_back import klc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  klc_cmd_t                cmd_i,
  input  wire logic               q_empty_i,
  output logic                    pop_o,
  output logic                    clearing_o,
  output logic                    result_valid_o,
  output logic [15:0]             cell_data_o,
  output logic [CELL_AW-1:0]      cursor_position_o,
  output logic [LINE_W-1:0]       line_length_o,
  output logic                    line_done_o
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_SCROLL = 3'd3;

  localparam logic [CELL_AW-1:0] LAST_CELL = CELL_AW'(CELL_TOTAL - 1);

  logic [2:0]          state_q, state_d;
  logic [CELL_AW-1:0]  addr_q, addr_d;
  logic [CELL_AW-1:0]  idx_q, idx_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [LINE_W-1:0]   line_q, line_d;
  logic                valid_q, valid_d;
  logic [15:0]         res_data_q, res_data_d;
  logic [CELL_AW-1:0]  res_cursor_q, res_cursor_d;
  logic [LINE_W-1:0]   res_len_q, res_len_d;
  logic                res_done_q, res_done_d;
  logic                rd_ok_q, rd_ok_d;
  logic                scroll;

  // screen memory, one write and one registered read per cycle
  logic [15:0]         mem [CELL_TOTAL];
  logic [15:0]         rd_q;
  logic                we, re;
  logic [CELL_AW-1:0]  wa, ra;
  logic [CELL_AW:0]    ra_ext;
  logic [15:0]         wd;

  assign ra = ra_ext[CELL_AW-1:0];

  always_comb begin
    state_d      = state_q;
    addr_d       = addr_q;
    idx_d        = idx_q;
    col_d        = col_q;
    row_d        = row_q;
    line_d       = line_q;
    valid_d      = 1'b0;
    res_data_d   = res_data_q;
    res_cursor_d = res_cursor_q;
    res_len_d    = res_len_q;
    res_done_d   = res_done_q;
    rd_ok_d      = rd_ok_q;
    pop_o        = 1'b0;
    scroll       = 1'b0;
    we           = 1'b0;
    wa           = addr_q;
    wd           = BLANK_CELL;
    re           = 1'b0;
    ra_ext       = '0;
    unique case (state_q)
      ST_CLEAR: begin
        we = 1'b1;
        if (addr_q == LAST_CELL) begin
          state_d = ST_IDLE;
          addr_d  = '0;
        end else begin
          addr_d = addr_q + CELL_AW'(1);
        end
      end
      ST_IDLE: begin
        if (!q_empty_i) begin
          pop_o      = 1'b1;
          res_data_d = '0;
          res_done_d = 1'b0;
          unique case (cmd_i.kind)
            KIND_READ: begin
              ra_ext  = {1'b0, cmd_i.addr};
              re      = (cmd_i.addr < CELL_AW'(CELL_TOTAL));
              rd_ok_d = re;
              state_d = ST_READ;
            end
            KIND_NOP: begin
            end
            KIND_ENTER: begin
              res_done_d = 1'b1;
              line_d     = '0;
              if (row_q == ROW_W'(ROWS - 1)) begin
                scroll = 1'b1;
              end else begin
                idx_d = idx_q + CELL_AW'(COLUMNS) - CELL_AW'(col_q);
                row_d = row_q + ROW_W'(1);
                col_d = '0;
              end
            end
            KIND_BACK: begin
              if (line_q != '0 && idx_q != '0) begin
                line_d = line_q - LINE_W'(1);
                idx_d  = idx_q - CELL_AW'(1);
                we     = 1'b1;
                wa     = idx_q - CELL_AW'(1);
                if (col_q == '0) begin
                  col_d = COL_W'(COLUMNS - 1);
                  row_d = row_q - ROW_W'(1);
                end else begin
                  col_d = col_q - COL_W'(1);
                end
              end
            end
            KIND_CHAR: begin
              we = 1'b1;
              wa = idx_q;
              wd = {cmd_i.attr, cmd_i.ch};
              if (line_q != LINE_W'(LINE_MAX - 1)) begin
                line_d = line_q + LINE_W'(1);
              end
              if (idx_q == LAST_CELL) begin
                scroll = 1'b1;
              end else begin
                idx_d = idx_q + CELL_AW'(1);
                if (col_q == COL_W'(COLUMNS - 1)) begin
                  col_d = '0;
                  row_d = row_q + ROW_W'(1);
                end else begin
                  col_d = col_q + COL_W'(1);
                end
              end
            end
            default: begin
            end
          endcase
          if (scroll) begin
            idx_d   = CELL_AW'(TOP_CELLS);
            row_d   = ROW_W'(ROWS - 1);
            col_d   = '0;
            addr_d  = '0;
            re      = 1'b1;
            ra_ext  = (CELL_AW + 1)'(COLUMNS);
            state_d = ST_SCROLL;
          end
          res_cursor_d = idx_d;
          res_len_d    = (cmd_i.kind == KIND_ENTER) ? line_q : line_d;
          valid_d      = !(scroll || cmd_i.kind == KIND_READ);
        end
      end
      ST_READ: begin
        res_data_d = rd_ok_q ? rd_q : '0;
        valid_d    = 1'b1;
        state_d    = ST_IDLE;
      end
      ST_SCROLL: begin
        // write cell addr_q from the row below, read one ahead for the next cycle
        we     = 1'b1;
        wd     = (addr_q < CELL_AW'(TOP_CELLS)) ? rd_q : BLANK_CELL;
        ra_ext = {1'b0, addr_q} + (CELL_AW + 1)'(COLUMNS + 1);
        re     = (ra_ext < (CELL_AW + 1)'(CELL_TOTAL));
        if (addr_q == LAST_CELL) begin
          valid_d = 1'b1;
          state_d = ST_IDLE;
        end else begin
          addr_d = addr_q + CELL_AW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      addr_q  <= '0;
      idx_q   <= '0;
      col_q   <= '0;
      row_q   <= '0;
      line_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      idx_q   <= idx_d;
      col_q   <= col_d;
      row_q   <= row_d;
      line_q  <= line_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_data_q   <= res_data_d;
    res_cursor_q <= res_cursor_d;
    res_len_q    <= res_len_d;
    res_done_q   <= res_done_d;
    rd_ok_q      <= rd_ok_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_q <= mem[ra];
    end
  end

  assign clearing_o        = (state_q == ST_CLEAR);
  assign result_valid_o    = valid_q;
  assign cell_data_o       = res_data_q;
  assign cursor_position_o = res_cursor_q;
  assign line_length_o     = res_len_q;
  assign line_done_o       = res_done_q;

  a_cursor_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q < CELL_AW'(CELL_TOTAL))
    else $error("cursor left the screen");

  a_cursor_matches_row_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(idx_q) == 32'(row_q) * COLUMNS + 32'(col_q))
    else $error("cursor index out of step with row and column");

  a_no_result_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !valid_q && !pop_o)
    else $error("item handled during clearing pass");

  a_scroll_end_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCROLL && addr_q == LAST_CELL) |=> valid_q)
    else $error("scroll finished without a result");

endmodule

`default_nettype wire

>>> hw/rtl/keyboard_line_editor_text_console.sv
// keyboard_line_editor_text_console: top level joining front, command queue and back
// depends on klc_pkg, klc_front, klc_queue and klc_back
`default_nettype none

// keyboard line editor on an 80x25 text console
//
// input channel: an item (op, scancode, cell_address) is taken at a rising edge with
// start high and busy low. op 0 feeds a set-1 scancode to the editor, op 1 reads
// one screen cell.
// config channel: cfg_data_i is written to the text attribute when cfg_valid_i and
// cfg_ready_o are both high; cfg_ready_o is always high.
// result channel: one result per item, shown for exactly one cycle with
// result_valid_o high; the receiver cannot stall, so results are never held.
// results: a scancode result is registered as the back takes the item from the queue;
// a read result also passes through the registered screen memory read and the read
// state. a scroll, caused by enter on the last row or typing into the last cell,
// copies the screen through the single memory port pair one cell a cycle.
// the back handles one item at a time and is held by a read or a scroll; a two-entry
// queue lets the front keep taking items during a scroll until it is full.
// reset: the screen is cleared to blanks by a pass over all 2000 cells, one cell a cycle,
// with busy high; cursor, line count and attribute reset at once.

module keyboard_line_editor_text_console import klc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               op_i,
  input  wire logic [7:0]         scancode_i,
  input  wire logic [CELL_AW-1:0] cell_address_i,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [7:0]         cfg_data_i,
  output logic                    result_valid_o,
  output logic [15:0]             cell_data_o,
  output logic [CELL_AW-1:0]      cursor_position_o,
  output logic [LINE_W-1:0]       line_length_o,
  output logic                    line_done_o
);

  klc_cmd_t push_cmd, head_cmd;
  logic     push, pop, q_full, q_empty, clearing;

  // front: accept, classify, attribute register
  klc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_o         (busy),
    .op_i           (op_i),
    .scancode_i     (scancode_i),
    .cell_address_i (cell_address_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .q_full_i       (q_full),
    .clearing_i     (clearing),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  // queue decouples the front from a long scroll in the back
  klc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // back: screen memory, cursor, line count, clearing and scrolling
  klc_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (head_cmd),
    .q_empty_i         (q_empty),
    .pop_o             (pop),
    .clearing_o        (clearing),
    .result_valid_o    (result_valid_o),
    .cell_data_o       (cell_data_o),
    .cursor_position_o (cursor_position_o),
    .line_length_o     (line_length_o),
    .line_done_o       (line_done_o)
  );

endmodule

`default_nettype wire
